[rtl/core/pbri_pkg.sv]
// Package with types, constants and helpers of the priority buffer insert unit.
package pbri_pkg;

    localparam int SLOTS = 16;
    localparam int PRI_BITS = 8;
    localparam int ID_BITS = 32;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int COUNT_BITS = $clog2(SLOTS + 1);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    localparam logic [1:0] STATUS_PLACED = 2'd0;
    localparam logic [1:0] STATUS_DISPLACED = 2'd1;
    localparam logic [1:0] STATUS_DISPATCHED = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    typedef struct packed {
        logic                func;
        logic [PRI_BITS-1:0] new_priority;
        logic [ID_BITS-1:0]  new_id;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [PRI_BITS-1:0]   item_priority;
        logic [ID_BITS-1:0]    item_id;
        logic [SLOT_BITS-1:0]  slot_index;
        logic [COUNT_BITS-1:0] occupancy;
    } rsp_t;

    typedef struct packed {
        logic [PRI_BITS-1:0] pri;
        logic [ID_BITS-1:0]  id;
    } entry_t;

    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] addr;
        entry_t               wdata;
    } ram_req_t;

    function automatic logic [SLOT_BITS-1:0] slot_add(
        input logic [SLOT_BITS-1:0] a,
        input logic [SLOT_BITS-1:0] b
    );
        logic [SLOT_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (SLOT_BITS + 1)'(SLOTS))
        begin
            sum = sum - (SLOT_BITS + 1)'(SLOTS);
        end
        return sum[SLOT_BITS-1:0];
    endfunction

endpackage

[rtl/core/pbri_entry_ram.sv]
// Single-port synchronous RAM with registered read data.
module pbri_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

[rtl/core/pbri_ctrl.sv]
// Sequencer that searches, scans and updates the slot buffer through the entry RAM.
module pbri_ctrl
    import pbri_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  req_t     req_data,
    output logic     res_valid,
    input  logic     res_stall,
    output rsp_t     res_data,
    output ram_req_t ram_req,
    input  entry_t   ram_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS = 3'd1;
    localparam logic [2:0] S_DISP = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0]            state_reg, state_next;
    req_t                  req_reg, req_next;
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [SLOT_BITS-1:0]  ptr_reg, ptr_next;
    logic [SLOT_BITS:0]    issue_reg, issue_next;
    logic                  pend_reg, pend_next;
    logic [SLOT_BITS-1:0]  cmp_idx_reg, cmp_idx_next;
    logic                  have_reg, have_next;
    entry_t                best_reg, best_next;
    logic [SLOT_BITS-1:0]  best_idx_reg, best_idx_next;
    rsp_t                  res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_t                  out_reg, out_next;

    logic [SLOTS-1:0]      free_rot;
    logic                  free_found;
    logic [SLOT_BITS-1:0]  free_off;
    logic [SLOT_BITS-1:0]  free_slot;
    entry_t                new_entry;

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign res_data = out_reg;
    assign new_entry = '{pri: req_reg.new_priority, id: req_reg.new_id};

    always_comb
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            free_rot[k] = ~valid_reg[slot_add(ptr_reg, SLOT_BITS'(k))];
        end
        free_found = 1'b0;
        free_off = '0;
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (free_rot[k])
            begin
                free_found = 1'b1;
                free_off = SLOT_BITS'(k);
            end
        end
        free_slot = slot_add(ptr_reg, free_off);
    end

    always_comb
    begin
        state_next = state_reg;
        req_next = req_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        ptr_next = ptr_reg;
        issue_next = issue_reg;
        pend_next = pend_reg;
        cmp_idx_next = cmp_idx_reg;
        have_next = have_reg;
        best_next = best_reg;
        best_idx_next = best_idx_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        ram_req = '{we: 1'b0, addr: ptr_reg, wdata: new_entry};

        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_data;
                    if (req_data.func == FUNC_INSERT)
                    begin
                        state_next = S_INS;
                    end
                    else if (count_reg == '0)
                    begin
                        res_next = '{status: STATUS_EMPTY, item_priority: '0, item_id: '0,
                                     slot_index: '0, occupancy: count_reg};
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        issue_next = '0;
                        pend_next = 1'b0;
                        have_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_INS:
            begin
                if (free_found)
                begin
                    ram_req = '{we: 1'b1, addr: free_slot, wdata: new_entry};
                    valid_next[free_slot] = 1'b1;
                    count_next = count_reg + COUNT_BITS'(1);
                    ptr_next = slot_add(free_slot, SLOT_BITS'(1));
                    res_next = '{status: STATUS_PLACED, item_priority: '0, item_id: '0,
                                 slot_index: free_slot,
                                 occupancy: count_reg + COUNT_BITS'(1)};
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                ram_req = '{we: 1'b1, addr: ptr_reg, wdata: new_entry};
                ptr_next = slot_add(ptr_reg, SLOT_BITS'(1));
                res_next = '{status: STATUS_DISPLACED, item_priority: ram_rdata.pri,
                             item_id: ram_rdata.id, slot_index: ptr_reg,
                             occupancy: count_reg};
                state_next = S_PUSH;
            end
            S_SCAN:
            begin
                if (issue_reg < (SLOT_BITS + 1)'(SLOTS))
                begin
                    ram_req.addr = issue_reg[SLOT_BITS-1:0];
                    issue_next = issue_reg + (SLOT_BITS + 1)'(1);
                    pend_next = 1'b1;
                    cmp_idx_next = issue_reg[SLOT_BITS-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && valid_reg[cmp_idx_reg])
                begin
                    if (!have_reg || ram_rdata.pri < best_reg.pri ||
                        (ram_rdata.pri == best_reg.pri && ram_rdata.id < best_reg.id))
                    begin
                        have_next = 1'b1;
                        best_next = ram_rdata;
                        best_idx_next = cmp_idx_reg;
                    end
                end
                if (issue_reg == (SLOT_BITS + 1)'(SLOTS) && !pend_reg)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    count_next = count_reg - COUNT_BITS'(1);
                    res_next = '{status: STATUS_DISPATCHED, item_priority: best_reg.pri,
                                 item_id: best_reg.id, slot_index: best_idx_reg,
                                 occupancy: count_reg - COUNT_BITS'(1)};
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            ptr_reg <= '0;
            issue_reg <= '0;
            pend_reg <= 1'b0;
            have_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            ptr_reg <= ptr_next;
            issue_reg <= issue_next;
            pend_reg <= pend_next;
            have_reg <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        cmp_idx_reg <= cmp_idx_next;
        best_reg <= best_next;
        best_idx_reg <= best_idx_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == COUNT_BITS'($countones(valid_reg)))
        else $error("Occupancy count disagrees with the valid bits.");

    a_write_only_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (state_reg == S_INS || state_reg == S_DISP))
        else $error("Entry RAM written outside an insert.");

    a_displace_after_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISP) |-> ($past(state_reg) == S_INS &&
                                   count_reg == COUNT_BITS'(SLOTS)))
        else $error("Displacement entered while a slot was free.");

    a_dispatch_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && state_next == S_PUSH) |-> (have_reg && valid_reg[best_idx_reg]))
        else $error("Dispatch finished without a valid winning entry.");

endmodule

[rtl/core/priority_buffer_ring_insert_unit.sv]
// Top level of the priority buffer insert unit: sequencer and entry RAM.
// An insert into a free slot writes the new entry straight into that slot.
// An insert into a full buffer reads the displaced entry first, then writes the new entry in its place.
// A dispatch scans the entry RAM one slot a cycle through its single port.
// A dispatch on an empty buffer answers with the empty status without a scan; one request is handled at a time.
// Reset clears the valid bits, the occupancy count and the next-slot pointer; the RAM is not cleared.
module priority_buffer_ring_insert_unit
    import pbri_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic res_valid,
    input  logic res_stall,
    output rsp_t res_data
);

    ram_req_t ram_req;
    entry_t   ram_rdata;

    pbri_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    pbri_entry_ram #(
        .DEPTH (SLOTS),
        .WIDTH ($bits(entry_t))
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

endmodule
